>>> sv/bsd_pkg.sv
// ---------------------------------------------------------------------------
// bsd_pkg: shared definitions for the button sequence code detector
// constants, code table, controller states and control/status structs
// ---------------------------------------------------------------------------
package bsd_pkg;

    // default ring size of the symbol history
    localparam int HISTORY_DEPTH_DEF = 20;

    // filler byte read back from history entries that were never written
    localparam logic [7:0] FILLER = 8'h31;

    // code table geometry
    localparam int CODE_COUNT   = 12;
    localparam int CODE_MAX_LEN = 8;
    localparam int STEP_W       = $clog2(CODE_MAX_LEN);
    localparam int MATCH_W      = 4;
    localparam int FLAG_COUNT   = 6;

    // debounce reload values
    localparam logic [3:0] RELOAD_SINGLE = 4'd12;
    localparam logic [3:0] RELOAD_NORMAL = 4'd6;

    // codes in file order, last letter in the low byte
    localparam logic [8*CODE_MAX_LEN-1:0] CODES [CODE_COUNT] = '{
        "WIZDIZWE", "UDIZDUZD", "UDZIDEZD", "UDIZDWZD",
        "UDIZDLZD", "UDIZDRZD", "DUZIDLZD", "UIZDLZDU",
        "IDZIDUIL", "ZDUIRILR", "LRZILZRL", "DANISIL"
    };

    localparam logic [3:0] CODE_LEN [CODE_COUNT] = '{
        4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8,
        4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd7
    };

    // first and last code that flips a toggle flag (zero based)
    localparam int TOGGLE_FIRST = 1;
    localparam int TOGGLE_LAST  = 6;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_READ,
        ST_DRAIN,
        ST_FINISH
    } bsd_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_word;
        logic eval;
        logic read_en;
        logic commit;
    } bsd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sym_stored;
        logic step_last;
        logic out_free;
    } bsd_status_t;

endpackage

>>> sv/bsd_channels.sv
// ---------------------------------------------------------------------------
// bsd channels: valid/ready interfaces of the code detector
// frame input, result output and configuration write
// ---------------------------------------------------------------------------
interface bsd_frame_if;
    logic        valid;
    logic        ready;
    logic [15:0] buttons;

    modport source (output valid, output buttons, input ready);
    modport sink   (input valid, input buttons, output ready);
endinterface

interface bsd_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic [3:0] code_match;
    logic [5:0] toggle_flags;

    modport source (output valid, output symbol, output code_match,
                    output toggle_flags, input ready);
    modport sink   (input valid, input symbol, input code_match,
                    input toggle_flags, output ready);
endinterface

interface bsd_cfg_if;
    logic valid;
    logic ready;
    logic single_step_mode;

    modport source (output valid, output single_step_mode, input ready);
    modport sink   (input valid, input single_step_mode, output ready);
endinterface

>>> sv/button_sequence_code_detector.sv
// ---------------------------------------------------------------------------
// button_sequence_code_detector: keypad sequence code lock
// debounces frame button words into letters, keeps a letter history ring
// and reports which fixed code the newest letters spell
// ---------------------------------------------------------------------------
//  channel  dir  payload                               transaction
//  frame    in   buttons[15:0]                         valid & ready
//  result   out  symbol[7:0] code_match[3:0]           valid & ready
//                toggle_flags[5:0]
//  cfg      in   single_step_mode                      valid (ready held high)
//
//  a frame that stores a letter passes through an evaluation state, eight
//  history reads through the single memory read port, a drain state for the
//  read latency and a commit state
//  any other frame goes from evaluation straight to the commit state
//  reset needs no clearing pass: history entries carry valid bits
//  a stalled result holds the commit, so the next frame is not yet taken
// ---------------------------------------------------------------------------
module button_sequence_code_detector #(
    parameter int HISTORY_DEPTH = bsd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    bsd_frame_if.sink     frame,
    bsd_result_if.source  result,
    bsd_cfg_if.sink       cfg
);

    bsd_pkg::bsd_cmd_t    cmd;
    bsd_pkg::bsd_status_t status;
    logic                 in_ready;

    // configuration writes are always taken
    assign cfg.ready   = 1'b1;
    assign frame.ready = in_ready;

    // controller
    bsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (frame.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    bsd_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .buttons      (frame.buttons),
        .cfg_valid    (cfg.valid),
        .cfg_data     (cfg.single_step_mode),
        .out_valid    (result.valid),
        .out_ready    (result.ready),
        .symbol       (result.symbol),
        .code_match   (result.code_match),
        .toggle_flags (result.toggle_flags)
    );

endmodule

>>> sv/bsd_hist_mem.sv
// ---------------------------------------------------------------------------
// bsd_hist_mem: symbol history ring storage
// one write and one registered read port, per-entry valid bits so that
// unwritten entries read as filler, and a clear input that empties all entries
// ---------------------------------------------------------------------------
module bsd_hist_mem #(
    parameter int HISTORY_DEPTH = bsd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [$clog2(HISTORY_DEPTH)-1:0] wr_addr,
    input  logic [7:0]                       wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(HISTORY_DEPTH)-1:0] rd_addr,
    output logic [7:0]                       rd_data,
    input  logic                             clr
);

    logic [7:0]               mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] valid_reg;
    logic [7:0]               rd_data_reg;
    logic                     rd_hit_reg;

    // storage array, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // entry valid bits and read hit flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (clr)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    // unwritten entries read as filler
    assign rd_data = rd_hit_reg ? rd_data_reg : bsd_pkg::FILLER;

endmodule

>>> sv/bsd_ctrl.sv
// ---------------------------------------------------------------------------
// bsd_ctrl: frame sequencing controller
// steps each frame through evaluation, a history walk when a letter is stored, and result commit
// ---------------------------------------------------------------------------
module bsd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bsd_pkg::bsd_status_t status,
    output bsd_pkg::bsd_cmd_t    cmd
);

    bsd_pkg::bsd_state_t state_reg;
    bsd_pkg::bsd_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bsd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bsd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bsd_pkg::ST_EVAL;
                end
            end
            bsd_pkg::ST_EVAL:
            begin
                state_next = status.sym_stored ? bsd_pkg::ST_READ : bsd_pkg::ST_FINISH;
            end
            bsd_pkg::ST_READ:
            begin
                if (status.step_last)
                begin
                    state_next = bsd_pkg::ST_DRAIN;
                end
            end
            bsd_pkg::ST_DRAIN:
            begin
                state_next = bsd_pkg::ST_FINISH;
            end
            bsd_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = bsd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bsd_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready      = 1'b0;
        cmd.load_word = 1'b0;
        cmd.eval      = 1'b0;
        cmd.read_en   = 1'b0;
        cmd.commit    = 1'b0;
        case (state_reg)
            bsd_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_word = in_valid;
            end
            bsd_pkg::ST_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            bsd_pkg::ST_READ:
            begin
                cmd.read_en = 1'b1;
            end
            bsd_pkg::ST_DRAIN:
            begin
                cmd.read_en = 1'b0;
            end
            bsd_pkg::ST_FINISH:
            begin
                cmd.commit = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> sv/bsd_datapath.sv
// ---------------------------------------------------------------------------
// bsd_datapath: debounce, symbol encode, history and code compare
// holds all frame state, walks the history one entry per cycle and
// checks every code against each entry in parallel
// ---------------------------------------------------------------------------
module bsd_datapath #(
    parameter int HISTORY_DEPTH = bsd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bsd_pkg::bsd_cmd_t    cmd,
    output bsd_pkg::bsd_status_t status,
    input  logic [15:0]          buttons,
    input  logic                 cfg_valid,
    input  logic                 cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           symbol,
    output logic [3:0]           code_match,
    output logic [5:0]           toggle_flags
);

    localparam int IDX_W = $clog2(HISTORY_DEPTH);

    // frame state
    logic [15:0]                        word_reg;
    logic                               mode_reg;
    logic [3:0]                         deb_reg;
    logic                               latch_reg;
    logic [7:0]                         last_reg;
    logic [5:0]                         toggles_reg;
    logic [IDX_W-1:0]                   cursor_reg;
    logic [7:0]                         sym_reg;
    logic [bsd_pkg::STEP_W-1:0]         step_reg;
    logic                               cmp_en_reg;
    logic [bsd_pkg::STEP_W-1:0]         cmp_step_reg;
    logic [bsd_pkg::CODE_COUNT-1:0]     alive_reg;
    logic [bsd_pkg::CODE_COUNT-1:0]     alive_next;

    // result register
    logic                               out_valid_reg;
    logic [7:0]                         out_sym_reg;
    logic [3:0]                         out_match_reg;
    logic [5:0]                         out_flags_reg;

    // evaluation terms
    logic [3:0]                         deb_dec;
    logic                               neutral;
    logic                               take;
    logic [7:0]                         sym_enc;
    logic                               stored;
    logic [IDX_W-1:0]                   cursor_inc;

    // history walk
    logic [IDX_W:0]                     rd_addr_ext;
    logic [IDX_W-1:0]                   rd_addr;
    logic [7:0]                         rd_data;

    // commit terms
    logic [3:0]                         match_idx;
    logic [5:0]                         flags_new;

    // priority encode, highest priority last so it overrides
    function automatic logic [7:0] encode_sym(input logic [15:0] w);
        logic [7:0] s;
        s = 8'h00;
        if (w[15]) s = "A";
        if (w[14]) s = "B";
        if (w[11]) s = "U";
        if (w[10]) s = "D";
        if (w[9])  s = "L";
        if (w[8])  s = "R";
        if (w[3])  s = "N";
        if (w[2])  s = "S";
        if (w[1])  s = "W";
        if (w[0])  s = "E";
        if (w[13]) s = "Z";
        if (w[5])  s = "I";
        if (w[4])  s = "T";
        return s;
    endfunction

    // frame evaluation
    always_comb
    begin
        deb_dec    = (deb_reg == 4'd0) ? 4'd0 : deb_reg - 4'd1;
        neutral    = !latch_reg && (word_reg == 16'h0000);
        take       = !neutral && (deb_dec == 4'd0) && (word_reg != 16'h0000) &&
                     ({8'h00, last_reg} != word_reg);
        sym_enc    = encode_sym(word_reg);
        stored     = take && (sym_enc != 8'h00);
        cursor_inc = (cursor_reg == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : cursor_reg + 1'b1;
    end

    // read address walks back from the cursor with wrap
    always_comb
    begin
        rd_addr_ext = {1'b0, cursor_reg}
                    + (({1'b0, cursor_reg} < (IDX_W+1)'(step_reg)) ?
                       (IDX_W+1)'(HISTORY_DEPTH) : '0)
                    - (IDX_W+1)'(step_reg);
        rd_addr     = rd_addr_ext[IDX_W-1:0];
    end

    bsd_hist_mem #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd.eval && stored),
        .wr_addr (cursor_inc),
        .wr_data (sym_enc),
        .rd_en   (cmd.read_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .clr     (cmd.commit && (match_idx != 4'd0))
    );

    // per-code compare of the entry read back
    always_comb
    begin
        alive_next = alive_reg;
        for (int k = 0; k < bsd_pkg::CODE_COUNT; k++)
        begin
            if ({1'b0, cmp_step_reg} < bsd_pkg::CODE_LEN[k])
            begin
                alive_next[k] = alive_reg[k] &&
                    (rd_data == bsd_pkg::CODES[k][{cmp_step_reg, 3'b000} +: 8]);
            end
        end
    end

    // first surviving code wins, toggle codes flip their flag
    always_comb
    begin
        match_idx = 4'd0;
        for (int k = bsd_pkg::CODE_COUNT - 1; k >= 0; k--)
        begin
            if (alive_reg[k])
            begin
                match_idx = 4'(k + 1);
            end
        end
        flags_new = toggles_reg;
        for (int k = bsd_pkg::TOGGLE_FIRST; k <= bsd_pkg::TOGGLE_LAST; k++)
        begin
            if (match_idx == 4'(k + 1))
            begin
                flags_new[k - bsd_pkg::TOGGLE_FIRST] = ~toggles_reg[k - bsd_pkg::TOGGLE_FIRST];
            end
        end
    end

    // input word capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_word)
        begin
            word_reg <= buttons;
        end
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b1;
            deb_reg      <= 4'd0;
            latch_reg    <= 1'b0;
            last_reg     <= 8'h00;
            toggles_reg  <= '0;
            cursor_reg   <= '0;
            sym_reg      <= 8'h00;
            step_reg     <= '0;
            cmp_en_reg   <= 1'b0;
            cmp_step_reg <= '0;
            alive_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                mode_reg <= cfg_data;
            end

            cmp_en_reg   <= cmd.read_en;
            cmp_step_reg <= step_reg;

            if (cmd.eval)
            begin
                step_reg  <= '0;
                alive_reg <= stored ? '1 : '0;
                if (neutral)
                begin
                    latch_reg <= 1'b1;
                    deb_reg   <= deb_dec;
                    sym_reg   <= 8'h00;
                end
                else
                begin
                    if (word_reg != 16'h0000)
                    begin
                        latch_reg <= 1'b0;
                    end
                    if (take)
                    begin
                        deb_reg  <= mode_reg ? bsd_pkg::RELOAD_SINGLE : bsd_pkg::RELOAD_NORMAL;
                        last_reg <= sym_enc;
                        sym_reg  <= sym_enc;
                    end
                    else
                    begin
                        deb_reg <= deb_dec;
                        sym_reg <= 8'h00;
                    end
                    if (stored)
                    begin
                        cursor_reg <= cursor_inc;
                    end
                end
            end
            else
            begin
                if (cmd.read_en)
                begin
                    step_reg <= step_reg + 1'b1;
                end
                if (cmp_en_reg)
                begin
                    alive_reg <= alive_next;
                end
            end

            if (cmd.commit)
            begin
                toggles_reg <= flags_new;
                if (match_idx != 4'd0)
                begin
                    cursor_reg <= '0;
                end
            end
        end
    end

    // result register, reloads when empty or while the old result is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_sym_reg   <= sym_reg;
            out_match_reg <= match_idx;
            out_flags_reg <= flags_new;
        end
    end

    // status back to the controller
    assign status.sym_stored = stored;
    assign status.step_last  = (step_reg == bsd_pkg::STEP_W'(bsd_pkg::CODE_MAX_LEN - 1));
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign symbol       = out_sym_reg;
    assign code_match   = out_match_reg;
    assign toggle_flags = out_flags_reg;

endmodule
